### hdl/pcc_pkg.sv
package pcc_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int CORR_W          = 16;
  localparam int PAIR_COUNT_W    = 17;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_PAIRS_DEF   = 65536;
  localparam int QUO_BITS        = 31;
  localparam int ROOT_BITS       = 16;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
    logic                last_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic                     degenerate;
    logic [PAIR_COUNT_W-1:0]  pair_count;
  } out_item_t;

  // products handled by the shared shift-add multiplier, in issue order
  typedef enum logic [2:0] {
    J_NSXY = 3'd0,
    J_SXSY = 3'd1,
    J_NSXX = 3'd2,
    J_SXSX = 3'd3,
    J_NSYY = 3'd4,
    J_SYSY = 3'd5,
    J_DEN  = 3'd6,
    J_MAG2 = 3'd7
  } job_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic run;
    logic store;
    job_t job;
    logic div_load;
    logic div_run;
    logic sqrt_run;
    logic emit;
  } pcc_cmd_t;

  typedef struct packed {
    logic last_fire;
    logic mul_done;
    logic prod_zero;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } pcc_status_t;

endpackage

### hdl/pcc_stream_if.sv
interface pcc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### hdl/pcc_ctrl.sv
module pcc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  pcc_pkg::pcc_status_t status,
  output pcc_pkg::pcc_cmd_t    cmd
);
  import pcc_pkg::*;

  typedef enum logic [7:0] {
    ST_ACC      = 8'b0000_0001,
    ST_LOAD     = 8'b0000_0010,
    ST_RUN      = 8'b0000_0100,
    ST_STORE    = 8'b0000_1000,
    ST_DIV_LOAD = 8'b0001_0000,
    ST_DIV_RUN  = 8'b0010_0000,
    ST_SQRT     = 8'b0100_0000,
    ST_OUT      = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  job_t   job, job_next;

  function automatic job_t next_job(input job_t j);
    job_t r;
    unique case (j)
      J_NSXY: r = J_SXSY;
      J_SXSY: r = J_NSXX;
      J_NSXX: r = J_SXSX;
      J_SXSX: r = J_NSYY;
      J_NSYY: r = J_SYSY;
      J_SYSY: r = J_DEN;
      J_DEN:  r = J_MAG2;
      J_MAG2: r = J_NSXY;
      default: r = J_NSXY;
    endcase
    return r;
  endfunction

  always_comb begin
    state_next = state;
    job_next   = job;
    cmd        = '0;
    cmd.job    = job;
    unique case (state)
      ST_ACC: begin
        cmd.accept = 1'b1;
        if (status.last_fire) begin
          state_next = ST_LOAD;
          job_next   = J_NSXY;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        cmd.run = 1'b1;
        if (status.mul_done) state_next = ST_STORE;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (job == J_MAG2) begin
          state_next = ST_DIV_LOAD;
        end else if (job == J_DEN && status.prod_zero) begin
          state_next = ST_OUT;
        end else begin
          job_next   = next_job(job);
          state_next = ST_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_run = 1'b1;
        if (status.div_done) state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_run = 1'b1;
        if (status.sqrt_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        cmd.emit = status.out_free;
        if (status.out_free) state_next = ST_ACC;
      end
      default: state_next = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
      job   <= J_NSXY;
    end else begin
      state <= state_next;
      job   <= job_next;
    end
  end

endmodule

### hdl/pcc_dp.sv
module pcc_dp #(
  parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_PAIRS   = pcc_pkg::MAX_PAIRS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  pcc_stream_if.sink           samples,
  pcc_stream_if.source         results,
  input  pcc_pkg::pcc_cmd_t    cmd,
  output pcc_pkg::pcc_status_t status
);
  import pcc_pkg::*;

  localparam int SW  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int CW  = $clog2(MAX_PAIRS + 1);
  localparam int SXW = SW + CW;
  localparam int SQW = 2 * SW + CW;
  localparam int PW  = 2 * SW + 2 * CW;
  localparam int DW  = 2 * PW;
  localparam int DCW = $clog2(QUO_BITS);
  localparam int RKW = $clog2(ROOT_BITS);

  logic [CW-1:0]        count;
  logic [SXW-1:0]       sum_x, sum_y;
  logic [SQW-1:0]       sum_xx, sum_yy, sum_xy;
  logic [PW-1:0]        p_r, mag, dx, dy;
  logic                 neg, degen;
  logic [DW-1:0]        mul_a, mul_acc, den, m2, rem;
  logic [PW-1:0]        mul_b;
  logic                 fb;
  logic [QUO_BITS-1:0]  quo;
  logic [DCW-1:0]       div_cnt;
  logic [ROOT_BITS-1:0] root;
  logic [RKW-1:0]       root_k;
  logic                 out_valid;
  out_item_t            out_data;

  logic [SW-1:0]          x, y;
  logic [2*SW-1:0]        xx, yy, xy;
  logic                   fire;
  logic [PW-1:0]          op_a, op_b, prod_lo;
  logic [DW:0]            div_trial;
  logic                   div_ge;
  logic [ROOT_BITS-1:0]   root_trial;
  logic [2*ROOT_BITS-1:0] root_sq;
  logic [CORR_W-1:0]      corr;

  assign x    = samples.data.x_sample[SW-1:0];
  assign y    = samples.data.y_sample[SW-1:0];
  assign xx   = x * x;
  assign yy   = y * y;
  assign xy   = x * y;
  assign fire = samples.valid && cmd.accept;

  assign samples.ready = cmd.accept;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  always_comb begin
    case (cmd.job)
      J_NSXY:  begin op_a = PW'(sum_xy); op_b = PW'(count); end
      J_SXSY:  begin op_a = PW'(sum_x);  op_b = PW'(sum_y); end
      J_NSXX:  begin op_a = PW'(sum_xx); op_b = PW'(count); end
      J_SXSX:  begin op_a = PW'(sum_x);  op_b = PW'(sum_x); end
      J_NSYY:  begin op_a = PW'(sum_yy); op_b = PW'(count); end
      J_SYSY:  begin op_a = PW'(sum_y);  op_b = PW'(sum_y); end
      J_DEN:   begin op_a = dx;          op_b = dy;         end
      J_MAG2:  begin op_a = mag;         op_b = mag;        end
      default: begin op_a = '0;          op_b = '0;         end
    endcase
  end

  assign prod_lo    = mul_acc[PW-1:0];
  assign div_trial  = {rem, fb};
  assign div_ge     = div_trial >= {1'b0, den};
  assign root_trial = root | (ROOT_BITS'(1) << root_k);
  assign root_sq    = root_trial * root_trial;

  always_comb begin
    if (degen) begin
      corr = '0;
    end else if (neg) begin
      corr = CORR_W'(0) - CORR_W'(root);
    end else if (root[ROOT_BITS-1]) begin
      corr = {1'b0, {(CORR_W-1){1'b1}}};
    end else begin
      corr = CORR_W'(root);
    end
  end

  always_comb begin
    status.last_fire = fire && samples.data.last_pair;
    status.mul_done  = (mul_b == '0);
    status.prod_zero = (mul_acc == '0);
    status.div_done  = (div_cnt == DCW'(QUO_BITS - 1));
    status.sqrt_done = (root_k == '0);
    status.out_free  = !out_valid;
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      count  <= '0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_xx <= '0;
      sum_yy <= '0;
      sum_xy <= '0;
    end else if (fire && count < CW'(MAX_PAIRS)) begin
      count  <= count + CW'(1);
      sum_x  <= sum_x + SXW'(x);
      sum_y  <= sum_y + SXW'(y);
      sum_xx <= sum_xx + SQW'(xx);
      sum_yy <= sum_yy + SQW'(yy);
      sum_xy <= sum_xy + SQW'(xy);
    end
  end

  // shift-add multiplier and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mul_a   <= DW'(op_a);
      mul_b   <= op_b;
      mul_acc <= '0;
    end else if (cmd.run) begin
      if (mul_b[0]) mul_acc <= mul_acc + mul_a;
      mul_a <= mul_a << 1;
      mul_b <= mul_b >> 1;
    end
    if (cmd.store) begin
      case (cmd.job)
        J_NSXY, J_NSXX, J_NSYY: p_r <= prod_lo;
        J_SXSY: begin
          neg <= p_r < prod_lo;
          mag <= (p_r < prod_lo) ? prod_lo - p_r : p_r - prod_lo;
        end
        J_SXSX: dx <= (p_r >= prod_lo) ? p_r - prod_lo : '0;
        J_SYSY: dy <= (p_r >= prod_lo) ? p_r - prod_lo : '0;
        J_DEN: begin
          den   <= mul_acc;
          degen <= (mul_acc == '0);
        end
        J_MAG2: m2 <= mul_acc;
        default: ;
      endcase
    end
  end

  // restoring divide of m2 * 2^30 by den, then bitwise square root
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem     <= m2 >> 1;
      fb      <= m2[0];
      quo     <= '0;
      div_cnt <= '0;
      root    <= '0;
      root_k  <= RKW'(ROOT_BITS - 1);
    end else if (cmd.div_run) begin
      rem     <= div_ge ? DW'(div_trial - {1'b0, den}) : div_trial[DW-1:0];
      fb      <= 1'b0;
      quo     <= {quo[QUO_BITS-2:0], div_ge};
      div_cnt <= div_cnt + DCW'(1);
    end else if (cmd.sqrt_run) begin
      if (root_sq <= (2*ROOT_BITS)'(quo)) root <= root_trial;
      root_k <= root_k - RKW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.correlation <= $signed(corr);
      out_data.degenerate  <= degen;
      out_data.pair_count  <= PAIR_COUNT_W'(count);
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PAIRS))
    else $error("pair count beyond limit");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (count == '0 && sum_x == '0 && sum_xy == '0))
    else $error("accumulators not cleared after result");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |-> out_data.correlation == '0)
    else $error("degenerate result with nonzero correlation");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_run |-> rem < den)
    else $error("divider remainder out of range");
`endif

endmodule

### hdl/pearson_correlation_chunk_unit.sv
// Pearson correlation over chunks of unsigned sample pairs. Pairs are taken one per cycle
// and summed exactly; the pair marked last closes the chunk and input is then held off
// while the coefficient is worked out by one shared shift-add multiplier (eight products,
// each shifting out its multiplier operand bit by bit: the count, a column
// sum, dy or the numerator magnitude, at most 2*SAMPLE_BITS + 2*clog2(MAX_PAIRS+1) bits),
// a restoring divide of 31 steps after a load, and a bitwise square root. The result then
// waits for the output register to empty; a zero-variance chunk skips the last product,
// the divide and the root.
// Results come out in signed Q1.15, truncated toward zero and held at +32767; a
// zero-variance column gives 0 with degenerate set.
// The result sits in an output register, so the next chunk may start while it waits.
module pearson_correlation_chunk_unit #(
  parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_PAIRS   = pcc_pkg::MAX_PAIRS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pcc_stream_if.sink   samples,
  pcc_stream_if.source results
);
  import pcc_pkg::*;

  pcc_cmd_t    cmd;
  pcc_status_t status;

  pcc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  pcc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_PAIRS   (MAX_PAIRS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cmd     (cmd),
    .status  (status)
  );

endmodule

### tb/sv/pcc_checker.sv
`timescale 1ns / 1ps

module pcc_checker #(
  parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_PAIRS   = pcc_pkg::MAX_PAIRS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  pcc_stream_if samples,
  pcc_stream_if results,
  output int    errors,
  output int    pending,
  output int    matched,
  output int    degen_seen
);
  import pcc_pkg::*;

  out_item_t      coeff_q[$];
  int unsigned    n_acc;
  logic [255:0]   sx, sy, sxx, syy, sxy;

  function automatic logic [255:0] spread(logic [255:0] n, logic [255:0] s1,
                                          logic [255:0] s2);
    logic [255:0] p;
    logic [255:0] q;
    p = n * s2;
    q = s1 * s1;
    return (p >= q) ? p - q : '0;
  endfunction

  function automatic out_item_t close_chunk();
    out_item_t    r;
    logic [255:0] n, p, q, mag, den, rhs, mid, lhs;
    logic [255:0] lo, hi;
    logic         neg;
    n   = n_acc;
    p   = n * sxy;
    q   = sx * sy;
    neg = p < q;
    mag = neg ? q - p : p - q;
    den = spread(n, sx, sxx) * spread(n, sy, syy);
    r.degenerate  = (den == 0);
    r.pair_count  = n_acc[PAIR_COUNT_W-1:0];
    r.correlation = '0;
    if (den != 0) begin
      rhs = (mag * mag) << 30;
      lo  = 0;
      hi  = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = mid * mid * den;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      if (neg) r.correlation = 16'(17'h10000 - lo[16:0]);
      else r.correlation = (lo > 32767) ? 16'sd32767 : 16'(lo[15:0]);
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    in_item_t     it;
    out_item_t    got, exp_r;
    logic [255:0] x, y;
    logic [63:0]  smask;
    if (rst) begin
      n_acc = 0;
      sx = '0; sy = '0; sxx = '0; syy = '0; sxy = '0;
      coeff_q.delete();
      errors = 0; matched = 0; degen_seen = 0;
    end else begin
      if (results.valid && results.ready) begin
        got = results.data;
        if (coeff_q.size() == 0) begin
          $display("%0t: unexpected result corr=%0d degen=%0b count=%0d", $time,
                   got.correlation, got.degenerate, got.pair_count);
          errors++;
        end else begin
          exp_r = coeff_q.pop_front();
          if (got.correlation !== exp_r.correlation) begin
            $display("%0t: correlation expected %0d got %0d", $time,
                     exp_r.correlation, got.correlation);
            errors++;
          end
          if (got.degenerate !== exp_r.degenerate) begin
            $display("%0t: degenerate expected %0b got %0b", $time,
                     exp_r.degenerate, got.degenerate);
            errors++;
          end
          if (got.pair_count !== exp_r.pair_count) begin
            $display("%0t: pair_count expected %0d got %0d", $time,
                     exp_r.pair_count, got.pair_count);
            errors++;
          end
          matched++;
          if (exp_r.degenerate) degen_seen++;
        end
      end
      if (samples.valid && samples.ready) begin
        it    = samples.data;
        smask = (64'd1 << SAMPLE_BITS) - 1;
        x     = it.x_sample & smask;
        y     = it.y_sample & smask;
        if (n_acc < MAX_PAIRS) begin
          n_acc++;
          sx  += x;
          sy  += y;
          sxx += x * x;
          syy += y * y;
          sxy += x * y;
        end
        if (it.last_pair) begin
          coeff_q.push_back(close_chunk());
          n_acc = 0;
          sx = '0; sy = '0; sxx = '0; syy = '0; sxy = '0;
        end
      end
    end
    pending = coeff_q.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import pcc_pkg::*;

  localparam int LIMIT   = 2_500_000;
  localparam int DRAIN   = 800;
  localparam int HOLD    = 2000;

  logic clk;
  logic rst;
  int   errors, pending, matched, degen_seen;
  int   cycles;
  int   pairs_sent, chunks_sent;
  bit   idle_on;
  bit   hold_req;
  bit   rx_hold;
  int   rx_gap;

  pcc_stream_if #(.T(in_item_t))  samples ();
  pcc_stream_if #(.T(out_item_t)) results ();

  pearson_correlation_chunk_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results)
  );

  pcc_checker chk (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .results    (results),
    .errors     (errors),
    .pending    (pending),
    .matched    (matched),
    .degen_seen (degen_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < LIMIT) @(posedge clk) cycles++;
    $display("timeout after %0d cycles", cycles);
    $display("[pearson_correlation_chunk_unit] ERROR");
    $finish;
  end

  // long receiver hold-off so the output register fills and input stalls
  initial begin
    rx_hold = 0;
    wait (hold_req);
    @(posedge clk);
    rx_hold = 1;
    repeat (HOLD) @(posedge clk);
    rx_hold = 0;
  end

  initial results.ready = 0;
  always @(posedge clk) begin
    if (rst || rx_hold) begin
      results.ready <= 0;
    end else if (rx_gap > 0) begin
      results.ready <= 0;
      rx_gap--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      results.ready <= 0;
      rx_gap = $urandom_range(0, 2);
    end else begin
      results.ready <= 1;
    end
  end

  task automatic send(input logic [15:0] x, input logic [15:0] y, input logic last);
    in_item_t it;
    it.x_sample  = x;
    it.y_sample  = y;
    it.last_pair = last;
    samples.valid <= 1;
    samples.data  <= it;
    do @(posedge clk); while (!samples.ready);
    pairs_sent++;
    if (last) chunks_sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      samples.valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_sample(int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 15));
      2: return 16'hFFFF - 16'($urandom_range(0, 15));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // shapes: 0 free, 1 y follows x, 2 y mirrors x, 3 constant x, 4 constant y
  task automatic rand_chunk(input int len);
    int          shape, kind, i;
    logic [15:0] x, y, cx, cy, noise;
    shape = $urandom_range(0, 4);
    kind  = $urandom_range(0, 3);
    cx    = pick_sample(kind);
    cy    = pick_sample(kind);
    for (i = 0; i < len; i++) begin
      x     = pick_sample(kind);
      noise = 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 0);
      case (shape)
        1: y = x + noise;
        2: y = ~x + noise;
        3: begin x = cx; y = pick_sample(kind); end
        4: y = cy;
        default: y = pick_sample(kind);
      endcase
      send(x, y, i == len - 1);
    end
  endtask

  initial begin
    int i, len, budget;
    rst           = 1;
    samples.valid = 0;
    samples.data  = '0;
    idle_on       = 1;
    hold_req      = 0;
    cycles        = 0;
    pairs_sent    = 0;
    chunks_sent   = 0;
    rx_gap        = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // single pairs: always zero variance
    send(16'h0000, 16'h0000, 1);
    send(16'hFFFF, 16'hFFFF, 1);
    // perfect positive: saturates
    send(16'd0, 16'd0, 0);
    send(16'd1, 16'd1, 0);
    send(16'd300, 16'd300, 0);
    send(16'hFFFF, 16'hFFFF, 1);
    // perfect negative
    send(16'd0, 16'hFFFF, 0);
    send(16'd100, 16'hFF9B, 0);
    send(16'hFFFF, 16'd0, 1);
    // constant x, then constant y
    send(16'd5, 16'd1, 0);
    send(16'd5, 16'd900, 0);
    send(16'd5, 16'hFFFF, 1);
    send(16'hAAAA, 16'h5555, 0);
    send(16'h5555, 16'h5555, 1);
    // mixed
    for (i = 0; i < 7; i++) send(16'($urandom), 16'($urandom), 0);
    send(16'($urandom), 16'($urandom), 1);

    budget = 1550;
    while (budget > 0) begin
      if (chunks_sent == 40) hold_req = 1;
      if (budget < 250) idle_on = 0;
      len = ($urandom_range(0, 30) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
      if (len > budget) len = budget;
      rand_chunk(len);
      budget -= len;
    end
    samples.valid <= 0;

    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
    $display("%0d pairs in %0d chunks, %0d coefficients checked (%0d degenerate)",
             pairs_sent, chunks_sent, matched, degen_seen);
    $display("covered extremes, +/-1, zero variance, long chunks and output stalls");
    if (errors == 0 && pending == 0) begin
      $display("[pearson_correlation_chunk_unit] OK");
    end else begin
      $display("[pearson_correlation_chunk_unit] ERROR");
    end
    $finish;
  end

endmodule

### pearson_correlation_chunk_unit.f
hdl/pcc_pkg.sv
hdl/pcc_stream_if.sv
hdl/pcc_ctrl.sv
hdl/pcc_dp.sv
hdl/pearson_correlation_chunk_unit.sv
tb/sv/pcc_checker.sv
tb/sv/tb.sv
